// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, all clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define PDIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition implies expectation in the same cycle
`define PDIR_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// condition implies expectation in the next cycle
`define PDIR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ===== design/pdir_pkg.sv =====
// ----------------------------------------------------------------------------
// pdir_pkg
// Types, constants and helpers of the pulse-distance IR frame decoder.
// ----------------------------------------------------------------------------
package pdir_pkg;

  localparam int MICROS_PER_TICK_DEF = 50;
  localparam int FRAME_BITS          = 16;
  localparam int FRAME_ITEMS         = 2 * FRAME_BITS + 4;
  localparam int STOP_POS            = 2 * FRAME_BITS + 3;

  localparam int DUR_W      = 16;
  localparam int POS_W      = 6;
  localparam int BIT_IDX_W  = $clog2(FRAME_BITS);
  localparam int CMD_W      = 8;
  localparam int ERR_W      = 3;
  localparam int TOL_W      = 7;
  localparam int EXC_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_VAL_W  = 16;
  localparam int US_W       = 11;
  localparam int FACT_W     = 8;
  localparam int PROD_W     = US_W + FACT_W;
  localparam int BND_W      = PROD_W + 1;
  localparam int NUM_WIN    = 5;
  localparam int WIN_W      = $clog2(NUM_WIN);
  localparam int QUEUE_DEPTH = 2;

  // nominal durations in microseconds
  localparam logic [US_W-1:0] HDR_MARK_US   = 11'd1060;
  localparam logic [US_W-1:0] HDR_SPACE_US  = 11'd1450;
  localparam logic [US_W-1:0] BIT_MARK_US   = 11'd534;
  localparam logic [US_W-1:0] ONE_SPACE_US  = 11'd468;
  localparam logic [US_W-1:0] ZERO_SPACE_US = 11'd1447;

  localparam logic [TOL_W-1:0]     TOL_RESET        = 7'd25;
  localparam logic [EXC_W-1:0]     EXCESS_RESET     = 8'd20;
  localparam logic [DUR_W-1:0]     REPEAT_GAP_RESET = 16'd1300;
  localparam logic [FACT_W-1:0]    PCT_FULL         = 8'd100;
  localparam logic [CMD_W-1:0]     INVERSE_MASK     = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE   = 2'd0,
    CFG_MARK_EXCESS = 2'd1,
    CFG_REPEAT_GAP  = 2'd2
  } cfg_index_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 3'd0,
    ERR_HEADER_MARK  = 3'd1,
    ERR_LENGTH       = 3'd2,
    ERR_HEADER_SPACE = 3'd3,
    ERR_BIT          = 3'd4,
    ERR_STOP         = 3'd5,
    ERR_INVERSE      = 3'd6
  } err_code_t;

  typedef enum logic [2:0] {
    KIND_GAP,
    KIND_HDR_MARK,
    KIND_HDR_SPACE,
    KIND_BIT_MARK,
    KIND_BIT_SPACE,
    KIND_STOP,
    KIND_NONE
  } kind_t;

  typedef enum logic [WIN_W-1:0] {
    WIN_HDR_MARK   = 3'd0,
    WIN_HDR_SPACE  = 3'd1,
    WIN_BIT_MARK   = 3'd2,
    WIN_ONE_SPACE  = 3'd3,
    WIN_ZERO_SPACE = 3'd4
  } win_t;

  typedef enum logic [1:0] {
    BND_MUL,
    BND_DIV,
    BND_STORE,
    BND_IDLE
  } bnd_state_t;

  // matching windows handed from the bound calculator to the back end
  typedef struct packed {
    logic [NUM_WIN-1:0][BND_W-1:0] lo;
    logic [NUM_WIN-1:0][BND_W-1:0] hi;
    logic [DUR_W-1:0]              repeat_gap;
  } bounds_t;

  // classified item travelling through the queue
  typedef struct packed {
    logic [DUR_W-1:0]     duration;
    kind_t                kind;
    logic [BIT_IDX_W-1:0] bit_index;
    logic                 last;
    logic                 short_frame;
    logic                 exact_len;
  } item_class_t;

  function automatic logic [US_W-1:0] win_nominal_us(input win_t win);
    logic [US_W-1:0] us;
    case (win)
      WIN_HDR_MARK:   us = HDR_MARK_US;
      WIN_HDR_SPACE:  us = HDR_SPACE_US;
      WIN_BIT_MARK:   us = BIT_MARK_US;
      WIN_ONE_SPACE:  us = ONE_SPACE_US;
      WIN_ZERO_SPACE: us = ZERO_SPACE_US;
      default:        us = '0;
    endcase
    return us;
  endfunction

  function automatic logic win_is_mark(input win_t win);
    return (win == WIN_HDR_MARK) || (win == WIN_BIT_MARK);
  endfunction

endpackage

// ===== design/pdir_if.sv =====
// ----------------------------------------------------------------------------
// pdir_if
// Valid/ready channels of the decoder: duration items, results, config.
// ----------------------------------------------------------------------------
interface pdir_item_if import pdir_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration_ticks;
  logic             last_of_frame;

  modport source(output valid, duration_ticks, last_of_frame, input ready);
  modport sink(input valid, duration_ticks, last_of_frame, output ready);
endinterface

interface pdir_result_if import pdir_pkg::*;;
  logic             valid;
  logic             ready;
  logic             decoded_ok;
  logic [CMD_W-1:0] command_byte;
  logic             is_repeat;
  logic [ERR_W-1:0] error_code;

  modport source(output valid, decoded_ok, command_byte, is_repeat, error_code,
                 input ready);
  modport sink(input valid, decoded_ok, command_byte, is_repeat, error_code,
               output ready);
endinterface

interface pdir_cfg_if import pdir_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_VAL_W-1:0] value;

  modport source(output valid, index, value, input ready);
  modport sink(input valid, index, value, output ready);
endinterface

// ===== design/pdir_bounds.sv =====
// ----------------------------------------------------------------------------
// pdir_bounds
// Configuration registers and the matching-window calculator: one multiply
// per bound and a reciprocal multiply for the division by the tick scale.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdir_bounds import pdir_pkg::*; #(
  parameter int MICROS_PER_TICK_P = MICROS_PER_TICK_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_VAL_W-1:0] cfg_value,
  output bounds_t              bounds,
  output logic                 bnd_ready
);

  localparam int DIVISOR   = MICROS_PER_TICK_P * 100;
  localparam int RCP_SHIFT = PROD_W + $clog2(DIVISOR);
  localparam int RCP_W     = PROD_W + 1;
  localparam int SCALED_W  = PROD_W + RCP_W;
  localparam longint unsigned RCP_FULL =
    ((64'd1 << RCP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP_MUL  = RCP_W'(RCP_FULL);
  localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(NUM_WIN - 1);

  logic [TOL_W-1:0]  tol;
  logic [EXC_W-1:0]  excess;
  logic [DUR_W-1:0]  repeat_gap;

  bnd_state_t        state, state_next;
  logic [WIN_W-1:0]  win_idx;
  logic              side_hi;
  logic [PROD_W-1:0] work;

  logic [NUM_WIN-1:0][BND_W-1:0] lo_bound;
  logic [NUM_WIN-1:0][BND_W-1:0] hi_bound;

  logic                cfg_fire;
  win_t                win;
  logic [US_W-1:0]     us_base;
  logic [US_W-1:0]     us_eff;
  logic [FACT_W-1:0]   factor;
  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] quot_full;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign bnd_ready = (state == BND_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tol        <= TOL_RESET;
      excess     <= EXCESS_RESET;
      repeat_gap <= REPEAT_GAP_RESET;
    end else if (cfg_fire) begin
      case (cfg_index_t'(cfg_index))
        CFG_TOLERANCE:   tol        <= cfg_value[TOL_W-1:0];
        CFG_MARK_EXCESS: excess     <= cfg_value[EXC_W-1:0];
        CFG_REPEAT_GAP:  repeat_gap <= cfg_value[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // nominal length and tolerance factor of the current window
  always_comb begin
    win     = win_t'(win_idx);
    us_base = win_nominal_us(win);
    if (win_is_mark(win)) begin
      us_eff = us_base + US_W'(excess);
    end else if (us_base > US_W'(excess)) begin
      us_eff = us_base - US_W'(excess);
    end else begin
      us_eff = '0;
    end
    if (side_hi) begin
      factor = PCT_FULL + FACT_W'(tol);
    end else if (FACT_W'(tol) >= PCT_FULL) begin
      factor = '0;
    end else begin
      factor = PCT_FULL - FACT_W'(tol);
    end
  end

  // division by the tick scale as a reciprocal multiply, exact over the product range
  always_comb begin
    scaled    = SCALED_W'(work) * SCALED_W'(RCP_MUL);
    quot_full = scaled >> RCP_SHIFT;
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BND_MUL;
      win_idx <= '0;
      side_hi <= 1'b0;
    end else if (cfg_fire) begin
      state   <= BND_MUL;
      win_idx <= '0;
      side_hi <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        BND_STORE: begin
          side_hi <= ~side_hi;
          if (side_hi) begin
            win_idx <= win_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      BND_MUL:   state_next = BND_DIV;
      BND_DIV:   state_next = BND_STORE;
      BND_STORE: state_next = (side_hi && win_idx == WIN_LAST) ? BND_IDLE : BND_MUL;
      BND_IDLE:  state_next = BND_IDLE;
      default:   state_next = BND_IDLE;
    endcase
  end

  // product, quotient and window storage
  always_ff @(posedge clk) begin
    case (state)
      BND_MUL: begin
        work <= PROD_W'(us_eff) * PROD_W'(factor);
      end
      BND_DIV: begin
        work <= quot_full[PROD_W-1:0];
      end
      BND_STORE: begin
        if (side_hi) begin
          hi_bound[win_idx] <= BND_W'(work) + 1'b1;
        end else begin
          lo_bound[win_idx] <= BND_W'(work);
        end
      end
      default: ;
    endcase
  end

  assign bounds.lo         = lo_bound;
  assign bounds.hi         = hi_bound;
  assign bounds.repeat_gap = repeat_gap;

  `PDIR_ASSERT_NEXT(a_cfg_restarts_bounds, cfg_fire, !bnd_ready, "window calc not restarted")

endmodule

// ===== design/pdir_front.sv =====
// ----------------------------------------------------------------------------
// pdir_front
// Accepts duration items, tracks the position in the frame and classifies
// each item before it enters the queue.
// ----------------------------------------------------------------------------
module pdir_front import pdir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DUR_W-1:0] duration_ticks,
  input  logic             last_of_frame,
  input  logic             bnd_ready,
  input  logic             queue_full,
  output logic             push,
  output item_class_t      push_data
);

  localparam logic [POS_W-1:0] POS_STOP  = POS_W'(STOP_POS);
  localparam logic [POS_W-1:0] POS_EXACT = POS_W'(FRAME_ITEMS - 1);
  localparam logic [POS_W-2:0] HALF_BASE = (POS_W - 1)'(2);

  logic [POS_W-1:0] item_position;
  logic [POS_W-2:0] half_pos_off;
  kind_t            kind;

  assign in_ready = bnd_ready && !queue_full;
  assign push     = in_valid && in_ready;

  // classify by position in the frame
  always_comb begin
    if (item_position == '0) begin
      kind = KIND_GAP;
    end else if (item_position == POS_W'(1)) begin
      kind = KIND_HDR_MARK;
    end else if (item_position == POS_W'(2)) begin
      kind = KIND_HDR_SPACE;
    end else if (item_position < POS_STOP) begin
      kind = item_position[0] ? KIND_BIT_MARK : KIND_BIT_SPACE;
    end else if (item_position == POS_STOP) begin
      kind = KIND_STOP;
    end else begin
      kind = KIND_NONE;
    end
    half_pos_off = item_position[POS_W-1:1] - HALF_BASE;
  end

  assign push_data.duration    = duration_ticks;
  assign push_data.kind        = kind;
  assign push_data.bit_index   = half_pos_off[BIT_IDX_W-1:0];
  assign push_data.last        = last_of_frame;
  assign push_data.short_frame = (item_position == '0);
  assign push_data.exact_len   = (item_position == POS_EXACT);

  // saturating position counter, cleared after the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_position <= '0;
    end else if (push) begin
      if (last_of_frame) begin
        item_position <= '0;
      end else if (item_position != '1) begin
        item_position <= item_position + 1'b1;
      end
    end
  end

endmodule

// ===== design/pdir_queue.sv =====
// ----------------------------------------------------------------------------
// pdir_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdir_queue import pdir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_class_t push_data,
  output logic        full,
  output logic        not_empty,
  input  logic        pop,
  output item_class_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_class_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `PDIR_ASSERT_NOW(a_no_push_when_full, full, !push, "item pushed into full queue")
  `PDIR_ASSERT_NOW(a_no_pop_when_empty, !not_empty, !pop, "item popped from empty queue")

endmodule

// ===== design/pdir_back.sv =====
// ----------------------------------------------------------------------------
// pdir_back
// Matches each queued duration against its window, collects bits and the
// first error, and registers one result on the last item of a frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdir_back import pdir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_present,
  input  item_class_t      entry,
  output logic             pop,
  input  bounds_t          bounds,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             decoded_ok,
  output logic [CMD_W-1:0] command_byte,
  output logic             is_repeat,
  output logic [ERR_W-1:0] error_code
);

  logic [FRAME_BITS-1:0] bit_shift, bit_shift_next;
  err_code_t             first_error, first_error_next;
  logic                  repeat_seen, repeat_seen_next;

  logic [BND_W-1:0]      dur_ext;
  logic [NUM_WIN-1:0]    win_ok;
  err_code_t             err_hit;
  err_code_t             frame_err;

  // all five windows compared at once
  always_comb begin
    dur_ext = BND_W'(entry.duration);
    for (int w = 0; w < NUM_WIN; w++) begin
      win_ok[w] = (dur_ext >= bounds.lo[w]) && (dur_ext <= bounds.hi[w]);
    end
  end

  // per-item update
  always_comb begin
    bit_shift_next   = bit_shift;
    repeat_seen_next = repeat_seen;
    err_hit          = ERR_NONE;
    case (entry.kind)
      KIND_GAP:       repeat_seen_next = (entry.duration < bounds.repeat_gap);
      KIND_HDR_MARK:  if (!win_ok[WIN_HDR_MARK]) err_hit = ERR_HEADER_MARK;
      KIND_HDR_SPACE: if (!win_ok[WIN_HDR_SPACE]) err_hit = ERR_HEADER_SPACE;
      KIND_BIT_MARK:  if (!win_ok[WIN_BIT_MARK]) err_hit = ERR_BIT;
      KIND_BIT_SPACE: begin
        if (win_ok[WIN_ONE_SPACE]) begin
          bit_shift_next[entry.bit_index] = 1'b1;
        end else if (!win_ok[WIN_ZERO_SPACE]) begin
          err_hit = ERR_BIT;
        end
      end
      KIND_STOP:      if (!win_ok[WIN_BIT_MARK]) err_hit = ERR_STOP;
      default: ;
    endcase
    first_error_next = (first_error == ERR_NONE) ? err_hit : first_error;
  end

  // frame verdict in priority order
  always_comb begin
    if (entry.short_frame || first_error_next == ERR_HEADER_MARK) begin
      frame_err = ERR_HEADER_MARK;
    end else if (!entry.exact_len) begin
      frame_err = ERR_LENGTH;
    end else if (first_error_next != ERR_NONE) begin
      frame_err = first_error_next;
    end else if ((bit_shift_next[CMD_W-1:0] ^ bit_shift_next[2*CMD_W-1:CMD_W])
                 != INVERSE_MASK) begin
      frame_err = ERR_INVERSE;
    end else begin
      frame_err = ERR_NONE;
    end
  end

  // a result needs a free output slot, other items pass straight through
  assign pop = item_present && (!entry.last || !out_valid || out_ready);

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift   <= '0;
      first_error <= ERR_NONE;
      repeat_seen <= 1'b0;
    end else if (pop) begin
      if (entry.last) begin
        bit_shift   <= '0;
        first_error <= ERR_NONE;
        repeat_seen <= 1'b0;
      end else begin
        bit_shift   <= bit_shift_next;
        first_error <= first_error_next;
        repeat_seen <= repeat_seen_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && entry.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      decoded_ok   <= (frame_err == ERR_NONE);
      command_byte <= (frame_err == ERR_NONE) ? bit_shift_next[CMD_W-1:0] : '0;
      is_repeat    <= (frame_err == ERR_NONE) && repeat_seen_next;
      error_code   <= frame_err;
    end
  end

  `PDIR_ASSERT_NEXT(a_result_follows_last, pop && entry.last, out_valid, "no result after last item")
  `PDIR_ASSERT_NEXT(a_state_cleared, pop && entry.last, bit_shift == '0 && first_error == ERR_NONE, "frame state not cleared")

endmodule

// ===== design/pulse_distance_ir_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// pulse_distance_ir_frame_decoder
// Pulse-distance IR frame decoder: one measured duration per item, one
// result per frame with the command byte, repeat flag and error code.
// ----------------------------------------------------------------------------
// Throughput: 1 item per cycle while the bounds are ready and the queue has
// room; the front, queue and back each move an item per cycle and the output
// register frees the back while a result waits. Reset clears the frame state
// and loads default configuration, then the window calculator computes the
// ten window bounds (3 steps per bound) with item ready low; every config
// write restarts that run.
module pulse_distance_ir_frame_decoder import pdir_pkg::*; #(
  parameter int MICROS_PER_TICK_P = MICROS_PER_TICK_DEF
) (
  input logic           clk,
  input logic           rst,
  pdir_item_if.sink     item,
  pdir_result_if.source result,
  pdir_cfg_if.sink      cfg
);

  bounds_t     bounds;
  logic        bnd_ready;
  logic        queue_full;
  logic        queue_not_empty;
  logic        push;
  logic        pop;
  item_class_t push_data;
  item_class_t pop_data;

  // configuration and matching windows
  pdir_bounds #(
    .MICROS_PER_TICK_P(MICROS_PER_TICK_P)
  ) u_bounds (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_value (cfg.value),
    .bounds    (bounds),
    .bnd_ready (bnd_ready)
  );

  // item intake and classification
  pdir_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .duration_ticks (item.duration_ticks),
    .last_of_frame  (item.last_of_frame),
    .bnd_ready      (bnd_ready),
    .queue_full     (queue_full),
    .push           (push),
    .push_data      (push_data)
  );

  // decoupling queue
  pdir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  // matching, bit collection and result
  pdir_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_present (queue_not_empty),
    .entry        (pop_data),
    .pop          (pop),
    .bounds       (bounds),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .decoded_ok   (result.decoded_ok),
    .command_byte (result.command_byte),
    .is_repeat    (result.is_repeat),
    .error_code   (result.error_code)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse-distance IR frame decoder. Frames are
// built from timing windows of the current register setting and fed with
// random gaps on the item side and random stalls on the result side. Every
// result is compared field by field with a table row's known outcome or
// with an in-bench decode of the same durations; the short table runs first.
// ----------------------------------------------------------------------------
module tb import pdir_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICK_US       = MICROS_PER_TICK_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRESSURE_HOLD = 300;
  localparam int ITEM_TARGET   = 800;
  localparam int PHASE_ITEMS   = 200;
  localparam int MAX_LEN       = 70;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [6:0]           NO_BAD    = 7'd127;

  typedef struct packed {
    logic             ok;
    logic [CMD_W-1:0] cmd;
    logic             rep;
    logic [ERR_W-1:0] err;
  } frame_result_t;

  // one directed frame: content, one optional bad duration, known outcome
  typedef struct packed {
    logic [DUR_W-1:0] gap;
    logic [CMD_W-1:0] cmd;
    logic [CMD_W-1:0] inv;
    logic [6:0]       len;
    logic [6:0]       bad_pos;
    logic [DUR_W-1:0] bad_dur;
    logic             typed;
    frame_result_t    want;
  } frame_row_t;

  localparam frame_result_t NO_WANT       = '0;
  localparam frame_result_t WANT_HDR_MARK = '{1'b0, 8'h00, 1'b0, ERR_HEADER_MARK};
  localparam frame_result_t WANT_HDR_SPC  = '{1'b0, 8'h00, 1'b0, ERR_HEADER_SPACE};
  localparam frame_result_t WANT_LENGTH   = '{1'b0, 8'h00, 1'b0, ERR_LENGTH};
  localparam frame_result_t WANT_BIT      = '{1'b0, 8'h00, 1'b0, ERR_BIT};
  localparam frame_result_t WANT_STOP     = '{1'b0, 8'h00, 1'b0, ERR_STOP};
  localparam frame_result_t WANT_INVERSE  = '{1'b0, 8'h00, 1'b0, ERR_INVERSE};

  localparam int DIRECTED_ROWS = 20;
  localparam frame_row_t DIRECTED [DIRECTED_ROWS] = '{
    // lone item, no header mark at all
    '{16'd0, 8'h00, 8'h00, 7'd1, NO_BAD, 16'd0, 1'b1, WANT_HDR_MARK},
    // gap and good header mark only
    '{16'd100, 8'h00, 8'h00, 7'd2, NO_BAD, 16'd0, 1'b1, WANT_LENGTH},
    '{16'd100, 8'h00, 8'h00, 7'd2, 7'd1, 16'd0, 1'b1, WANT_HDR_MARK},
    // good frames, command extremes and repeat threshold
    '{16'd0, 8'h00, 8'hFF, 7'(FRAME_ITEMS), NO_BAD, 16'd0, 1'b1,
      '{1'b1, 8'h00, 1'b1, ERR_NONE}},
    '{16'hFFFF, 8'hFF, 8'h00, 7'(FRAME_ITEMS), NO_BAD, 16'd0, 1'b1,
      '{1'b1, 8'hFF, 1'b0, ERR_NONE}},
    '{16'd1299, 8'hA5, 8'h5A, 7'(FRAME_ITEMS), NO_BAD, 16'd0, 1'b1,
      '{1'b1, 8'hA5, 1'b1, ERR_NONE}},
    '{16'd1300, 8'h3C, 8'hC3, 7'(FRAME_ITEMS), NO_BAD, 16'd0, 1'b1,
      '{1'b1, 8'h3C, 1'b0, ERR_NONE}},
    // second byte not the inverse
    '{16'd2000, 8'h12, 8'h34, 7'(FRAME_ITEMS), NO_BAD, 16'd0, 1'b1, WANT_INVERSE},
    // single timing faults
    '{16'd2000, 8'h81, 8'h7E, 7'(FRAME_ITEMS), 7'd2, 16'd0, 1'b1, WANT_HDR_SPC},
    '{16'd2000, 8'h81, 8'h7E, 7'(FRAME_ITEMS), 7'd5, 16'hFFFF, 1'b1, WANT_BIT},
    '{16'd2000, 8'h81, 8'h7E, 7'(FRAME_ITEMS), 7'd4, 16'd0, 1'b1, WANT_BIT},
    '{16'd2000, 8'h81, 8'h7E, 7'(FRAME_ITEMS), 7'(STOP_POS), 16'd0, 1'b1, WANT_STOP},
    // one item too many, one too few, far too many
    '{16'd2000, 8'h81, 8'h7E, 7'(FRAME_ITEMS + 1), NO_BAD, 16'd0, 1'b1, WANT_LENGTH},
    '{16'd2000, 8'h81, 8'h7E, 7'(FRAME_ITEMS - 1), NO_BAD, 16'd0, 1'b1, WANT_LENGTH},
    '{16'd2000, 8'h81, 8'h7E, 7'(MAX_LEN), NO_BAD, 16'd0, 1'b1, WANT_LENGTH},
    // bad header mark outranks a short frame
    '{16'd2000, 8'h81, 8'h7E, 7'd5, 7'd1, 16'd0, 1'b1, WANT_HDR_MARK},
    // window edges, decoded in the bench
    '{16'd500, 8'h55, 8'hAA, 7'(FRAME_ITEMS), 7'd1, 16'd28, 1'b0, NO_WANT},
    '{16'd500, 8'h55, 8'hAA, 7'(FRAME_ITEMS), 7'd1, 16'd29, 1'b0, NO_WANT},
    '{16'd500, 8'h55, 8'hAA, 7'(FRAME_ITEMS), 7'd6, 16'd13, 1'b0, NO_WANT},
    '{16'd500, 8'h55, 8'hAA, 7'(FRAME_ITEMS), 7'd3, 16'd8, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pdir_item_if   item_ch();
  pdir_result_if result_ch();
  pdir_cfg_if    cfg_ch();

  pulse_distance_ir_frame_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  // register copy
  logic [TOL_W-1:0] tol_pct      = TOL_RESET;
  logic [EXC_W-1:0] excess_us    = EXCESS_RESET;
  logic [DUR_W-1:0] repeat_limit = REPEAT_GAP_RESET;

  // frame state of the decode
  logic [POS_W-1:0] frame_pos = '0;
  logic [15:0]      bits_acc  = '0;
  logic [ERR_W-1:0] first_err = ERR_NONE;
  logic             rep_flag  = 1'b0;

  frame_result_t results_due [$];
  frame_result_t due;
  int mismatches  = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  int recv_roll;
  bit hold_start   = 1'b0;
  bit send_steady  = 1'b0;
  bit recv_steady  = 1'b0;

  always #5 clk = ~clk;

  // window of a nominal length under the current tolerance
  function automatic void window_bounds(input int unsigned us, output int unsigned lo,
                                        output int unsigned hi);
    int unsigned lower_pct;
    lower_pct = (tol_pct >= PCT_FULL) ? 0 : PCT_FULL - tol_pct;
    lo = us * lower_pct / (TICK_US * PCT_FULL);
    hi = us * (PCT_FULL + tol_pct) / (TICK_US * PCT_FULL) + 1;
  endfunction

  function automatic int unsigned mark_span(input int unsigned us);
    return us + excess_us;
  endfunction

  function automatic int unsigned space_span(input int unsigned us);
    return (us > excess_us) ? us - excess_us : 0;
  endfunction

  function automatic bit in_window(input int unsigned d, input int unsigned us);
    int unsigned lo, hi;
    window_bounds(us, lo, hi);
    return (d >= lo) && (d <= hi);
  endfunction

  function automatic logic [DUR_W-1:0] pick_window(input int unsigned us);
    int unsigned lo, hi;
    window_bounds(us, lo, hi);
    return DUR_W'($urandom_range(hi, lo));
  endfunction

  function automatic void note_error(input logic [ERR_W-1:0] code);
    if (first_err == ERR_NONE) first_err = code;
  endfunction

  // decode one duration; returns 1 when the item closes a frame
  function automatic bit decode_duration(input logic [DUR_W-1:0] d, input logic l,
                                         output frame_result_t r);
    int pos;
    logic [ERR_W-1:0] err;
    r = '0;
    pos = frame_pos;
    if (pos == 0) begin
      rep_flag = (d < repeat_limit);
    end else if (pos == 1) begin
      if (!in_window(d, mark_span(HDR_MARK_US))) note_error(ERR_HEADER_MARK);
    end else if (pos == 2) begin
      if (!in_window(d, space_span(HDR_SPACE_US))) note_error(ERR_HEADER_SPACE);
    end else if (pos < STOP_POS) begin
      if (pos % 2 == 1) begin
        if (!in_window(d, mark_span(BIT_MARK_US))) note_error(ERR_BIT);
      end else if (in_window(d, space_span(ONE_SPACE_US))) begin
        bits_acc[(pos - 3) / 2] = 1'b1;
      end else if (!in_window(d, space_span(ZERO_SPACE_US))) begin
        note_error(ERR_BIT);
      end
    end else if (pos == STOP_POS) begin
      if (!in_window(d, mark_span(BIT_MARK_US))) note_error(ERR_STOP);
    end
    if (!l) begin
      if (frame_pos != '1) frame_pos++;
      return 1'b0;
    end
    // error priority: header mark, length, first timing fault, inverse byte
    if (pos + 1 < 2 || first_err == ERR_HEADER_MARK) err = ERR_HEADER_MARK;
    else if (pos + 1 != FRAME_ITEMS) err = ERR_LENGTH;
    else if (first_err != ERR_NONE) err = first_err;
    else if ((bits_acc[7:0] ^ bits_acc[15:8]) != INVERSE_MASK) err = ERR_INVERSE;
    else err = ERR_NONE;
    r.err = err;
    r.ok  = (err == ERR_NONE);
    r.cmd = r.ok ? bits_acc[7:0] : '0;
    r.rep = r.ok ? rep_flag : 1'b0;
    frame_pos = '0;
    bits_acc  = '0;
    first_err = ERR_NONE;
    rep_flag  = 1'b0;
    return 1'b1;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_VAL_W-1:0] val);
    case (idx)
      CFG_TOLERANCE:   tol_pct = val[TOL_W-1:0];
      CFG_MARK_EXCESS: excess_us = val[EXC_W-1:0];
      CFG_REPEAT_GAP:  repeat_limit = val[DUR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int sender_idle();
    int r;
    if (send_steady) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [DUR_W-1:0] random_duration();
    if ($urandom_range(1)) return DUR_W'($urandom_range(100, 0));
    return DUR_W'($urandom);
  endfunction

  // leading gap on both sides of the repeat limit
  function automatic logic [DUR_W-1:0] gap_pick();
    int r;
    r = $urandom_range(99);
    if (r < 45) return DUR_W'($urandom_range(repeat_limit, 0));
    if (r < 90) return DUR_W'($urandom_range(16'hFFFF, repeat_limit));
    return DUR_W'($urandom);
  endfunction

  // offer one item, wait for it to be taken, then decode it
  task automatic put_item(input logic [DUR_W-1:0] d, input logic l, input bit use_typed,
                          input frame_result_t typed);
    frame_result_t decoded;
    int idle;
    idle = sender_idle();
    if (idle > 0) begin
      item_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.duration_ticks <= d;
    item_ch.last_of_frame  <= l;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
    if (decode_duration(d, l, decoded)) results_due.push_back(use_typed ? typed : decoded);
  endtask

  // build a frame from the current windows, optionally with one bad duration
  task automatic send_frame(input logic [DUR_W-1:0] gap, input logic [CMD_W-1:0] cmd,
                            input logic [CMD_W-1:0] inv, input int len, input int bad_pos,
                            input logic [DUR_W-1:0] bad_dur, input bit noise,
                            input bit use_typed, input frame_result_t typed);
    logic [15:0] word;
    logic [DUR_W-1:0] d;
    word = {inv, cmd};
    for (int p = 0; p < len; p++) begin
      if (noise) d = random_duration();
      else if (p == 0) d = gap;
      else if (p == 1) d = pick_window(mark_span(HDR_MARK_US));
      else if (p == 2) d = pick_window(space_span(HDR_SPACE_US));
      else if (p < STOP_POS && p % 2 == 1) d = pick_window(mark_span(BIT_MARK_US));
      else if (p < STOP_POS && word[(p - 3) / 2]) d = pick_window(space_span(ONE_SPACE_US));
      else if (p < STOP_POS) d = pick_window(space_span(ZERO_SPACE_US));
      else if (p == STOP_POS) d = pick_window(mark_span(BIT_MARK_US));
      else d = random_duration();
      if (p == bad_pos) d = bad_dur;
      put_item(d, p == len - 1, use_typed, typed);
    end
  endtask

  task automatic random_frame();
    logic [CMD_W-1:0] cmd, inv;
    int r;
    cmd = CMD_W'($urandom);
    inv = ($urandom_range(99) < 85) ? ~cmd : CMD_W'($urandom);
    r = $urandom_range(99);
    if (r < 65)
      send_frame(gap_pick(), cmd, inv, FRAME_ITEMS, NO_BAD, '0, 1'b0, 1'b0, NO_WANT);
    else if (r < 82)
      send_frame(gap_pick(), cmd, inv, FRAME_ITEMS, $urandom_range(FRAME_ITEMS - 1, 0),
                 random_duration(), 1'b0, 1'b0, NO_WANT);
    else if (r < 94)
      send_frame(gap_pick(), cmd, inv, $urandom_range(MAX_LEN, 1), NO_BAD, '0, 1'b0, 1'b0,
                 NO_WANT);
    else
      send_frame('0, cmd, inv, $urandom_range(10, 1), NO_BAD, '0, 1'b1, 1'b0, NO_WANT);
  endtask

  // stop offering items until every result is in and the pipe is empty
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_VAL_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_write(idx, val);
  endtask

  task automatic program_regs(input logic [CFG_VAL_W-1:0] tol, input logic [CFG_VAL_W-1:0] exc,
                              input logic [CFG_VAL_W-1:0] gap, input bit poke_spare);
    wait_idle();
    set_reg(CFG_TOLERANCE, tol);
    set_reg(CFG_MARK_EXCESS, exc);
    set_reg(CFG_REPEAT_GAP, gap);
    if (poke_spare) set_reg(CFG_SPARE, 16'hFFFF);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result side: check each taken result, then pick ready for the next edge
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual ok %0b cmd %0h rep %0b err %0d",
                   $time, result_ch.decoded_ok, result_ch.command_byte, result_ch.is_repeat,
                   result_ch.error_code);
        end else begin
          due = results_due.pop_front();
          check_field("decoded_ok", due.ok, result_ch.decoded_ok);
          check_field("command_byte", due.cmd, result_ch.command_byte);
          check_field("is_repeat", due.rep, result_ch.is_repeat);
          check_field("error_code", due.err, result_ch.error_code);
        end
      end
      if (hold_start) begin
        stall_left = PRESSURE_HOLD;
        hold_start = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (recv_steady) begin
        result_ch.ready <= 1'b1;
      end else begin
        recv_roll = $urandom_range(99);
        if (recv_roll < 75) begin
          result_ch.ready <= 1'b1;
        end else begin
          result_ch.ready <= 1'b0;
          stall_left = (recv_roll < 97) ? $urandom_range(2, 0) : $urandom_range(50, 10);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int start_items, phase;
    item_ch.valid          <= 1'b0;
    item_ch.duration_ticks <= '0;
    item_ch.last_of_frame  <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= CFG_TOLERANCE;
    cfg_ch.value           <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed frames at the reset setting
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_frame(DIRECTED[i].gap, DIRECTED[i].cmd, DIRECTED[i].inv, DIRECTED[i].len,
                 DIRECTED[i].bad_pos, DIRECTED[i].bad_dur, 1'b0, DIRECTED[i].typed,
                 DIRECTED[i].want);

    // back-pressure: results held off while short frames keep coming
    wait_idle();
    hold_start  = 1'b1;
    send_steady = 1'b1;
    repeat (40) send_frame('0, '0, '0, $urandom_range(2, 1), NO_BAD, '0, 1'b1, 1'b0, NO_WANT);
    send_steady = 1'b0;

    // random frames under a series of register settings
    start_items = items_sent;
    phase = 0;
    while (items_sent - start_items < ITEM_TARGET) begin
      case (phase)
        0:       program_regs(16'd0, 16'd0, 16'd0, 1'b0);
        1:       program_regs(16'd100, 16'd255, 16'hFFFF, 1'b0);
        2:       program_regs(16'd127, 16'd128, 16'd700, 1'b1);
        default: program_regs(CFG_VAL_W'($urandom_range(127, 0)),
                              CFG_VAL_W'($urandom_range(255, 0)),
                              CFG_VAL_W'($urandom), 1'b0);
      endcase
      send_steady = (phase % 4 == 2);
      recv_steady = (phase % 4 == 2);
      phase++;
      while (items_sent - start_items < phase * PHASE_ITEMS) random_frame();
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;

    wait_idle();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/pdir_pkg.sv
design/pdir_if.sv
design/pdir_bounds.sv
design/pdir_front.sv
design/pdir_queue.sv
design/pdir_back.sv
design/pulse_distance_ir_frame_decoder.sv
test/tb.sv
